### src/assert_macros.svh
// Assertion macros used by the checker file ssbe_checker.sv.
// Each use expands to one labelled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SSBE_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ssbe: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define SSBE_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ssbe: next-cycle check failed");

`endif

### src/ssbe_pkg.sv
// Shared types and constants of the swept box envelope block.
// No dependencies; used by the interfaces, controller, datapath, top level and testbench.
package ssbe_pkg;

  localparam int NUM_AXES  = 3;
  localparam int ENV_W     = 32;
  localparam int REG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BOX_VALID    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SCENE_EXTENT = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_E2, ST_E2SAVE, ST_AXINIT, ST_R0,
    ST_RTINIT, ST_RT, ST_TRAVEL, ST_WIDEN, ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_MUL, OP_E2SAVE, OP_AXINIT,
    OP_RTINIT, OP_RTSTEP, OP_TRAVEL, OP_WIDEN, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic s_zero;
    logic last;
    logic out_free;
  } status_t;

endpackage

### src/ssbe_if.sv
// Handshake channel interfaces: direction input, envelope output, register write.
// Depends on ssbe_pkg for the output and register index widths.
interface ssbe_in_if #(
  parameter int DIR_BITS = 16
) ();
  logic                       valid;
  logic                       ready;
  logic signed [DIR_BITS-1:0] dir_x;
  logic signed [DIR_BITS-1:0] dir_y;
  logic signed [DIR_BITS-1:0] dir_z;
  logic                       last_direction;

  modport source (output valid, dir_x, dir_y, dir_z, last_direction, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, last_direction, output ready);
endinterface

interface ssbe_out_if ();
  logic                              valid;
  logic                              ready;
  logic                              env_valid;
  logic signed [ssbe_pkg::ENV_W-1:0] env_min_x;
  logic signed [ssbe_pkg::ENV_W-1:0] env_min_y;
  logic signed [ssbe_pkg::ENV_W-1:0] env_min_z;
  logic signed [ssbe_pkg::ENV_W-1:0] env_max_x;
  logic signed [ssbe_pkg::ENV_W-1:0] env_max_y;
  logic signed [ssbe_pkg::ENV_W-1:0] env_max_z;

  modport source (output valid, env_valid, env_min_x, env_min_y, env_min_z,
                  env_max_x, env_max_y, env_max_z, input ready);
  modport sink   (input valid, env_valid, env_min_x, env_min_y, env_min_z,
                  env_max_x, env_max_y, env_max_z, output ready);
endinterface

interface ssbe_cfg_if #(
  parameter int COORD_BITS = 31
) ();
  logic                                valid;
  logic                                ready;
  logic [ssbe_pkg::REG_IDX_W-1:0]      index;
  logic [COORD_BITS-1:0]               data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/ssbe_ctrl.sv
// Sequencer of the swept box envelope: steps the datapath through one direction.
// Depends on ssbe_pkg (state_e, cmd_t, status_t).
module ssbe_ctrl #(
  parameter int DIR_BITS   = 16,
  parameter int COORD_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ssbe_pkg::status_t st_i,
  output ssbe_pkg::cmd_t    cmd_o
);
  import ssbe_pkg::*;

  localparam int KB   = COORD_BITS + 1;
  localparam int MAXN = (KB > 2 * DIR_BITS) ? KB : 2 * DIR_BITS;
  localparam int CNTW = $clog2(MAXN + 1);

  state_e            state_q, state_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [1:0]        axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.axis = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        if (st_i.s_zero) begin
          state_d = ST_WIDEN;
        end else begin
          cnt_d   = CNTW'(COORD_BITS);
          state_d = ST_E2;
        end
      end
      ST_E2: begin
        cmd_o.op = OP_MUL;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) state_d = ST_E2SAVE;
      end
      ST_E2SAVE: begin
        cmd_o.op = OP_E2SAVE;
        axis_d   = '0;
        state_d  = ST_AXINIT;
      end
      ST_AXINIT: begin
        cmd_o.op = OP_AXINIT;
        cnt_d    = CNTW'(2 * DIR_BITS);
        state_d  = ST_R0;
      end
      ST_R0: begin
        cmd_o.op = OP_MUL;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) state_d = ST_RTINIT;
      end
      ST_RTINIT: begin
        cmd_o.op = OP_RTINIT;
        cnt_d    = CNTW'(KB);
        state_d  = ST_RT;
      end
      ST_RT: begin
        cmd_o.op = OP_RTSTEP;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) state_d = ST_TRAVEL;
      end
      ST_TRAVEL: begin
        cmd_o.op = OP_TRAVEL;
        if (axis_q == 2'(NUM_AXES - 1)) begin
          state_d = ST_WIDEN;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_AXINIT;
        end
      end
      ST_WIDEN: begin
        cmd_o.op = OP_WIDEN;
        state_d  = st_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### src/ssbe_dp.sv
// Datapath of the swept box envelope: registers, shift-add multiplier,
// bit-serial root search, envelope accumulators and output register. Uses ssbe_pkg.
module ssbe_dp #(
  parameter int DIR_BITS   = 16,
  parameter int COORD_BITS = 31
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssbe_pkg::cmd_t                      cmd_i,
  output ssbe_pkg::status_t                   st_o,
  input  logic signed [DIR_BITS-1:0]          dir_x_i,
  input  logic signed [DIR_BITS-1:0]          dir_y_i,
  input  logic signed [DIR_BITS-1:0]          dir_z_i,
  input  logic                                last_direction_i,
  input  logic                                cfg_we_i,
  input  logic [ssbe_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  logic [COORD_BITS-1:0]               cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                env_valid_o,
  output logic [ssbe_pkg::ENV_W-1:0]          env_min_x_o,
  output logic [ssbe_pkg::ENV_W-1:0]          env_min_y_o,
  output logic [ssbe_pkg::ENV_W-1:0]          env_min_z_o,
  output logic [ssbe_pkg::ENV_W-1:0]          env_max_x_o,
  output logic [ssbe_pkg::ENV_W-1:0]          env_max_y_o,
  output logic [ssbe_pkg::ENV_W-1:0]          env_max_z_o
);
  import ssbe_pkg::*;

  localparam int SW   = 2 * DIR_BITS + 2;
  localparam int MW   = 2 * DIR_BITS + 2 * COORD_BITS;
  localparam int PLW  = (COORD_BITS > 2 * DIR_BITS) ? COORD_BITS : 2 * DIR_BITS;
  localparam int RW   = MW + 2;
  localparam int KB   = COORD_BITS + 1;
  localparam int CW   = 2 * KB + SW;
  localparam int AW   = COORD_BITS + 2;
  localparam int SATW = (AW > ENV_W) ? AW : ENV_W;

  // configuration
  logic signed [COORD_BITS-1:0] box_min_q [NUM_AXES];
  logic signed [COORD_BITS-1:0] box_max_q [NUM_AXES];
  logic                         box_valid_q;
  logic [COORD_BITS-1:0]        ext_q;

  // per-item operands
  logic [DIR_BITS-1:0]          ad_q   [NUM_AXES];
  logic                         dpos_q [NUM_AXES];
  logic                         last_q;
  logic [SW-1:0]                s_q;
  logic [2*COORD_BITS-1:0]      e2_q;

  // shift-add multiplier
  logic [MW-1:0]                mcand_q, prod_q;
  logic [PLW-1:0]               mplier_q;

  // root search: largest k with k^2 * s <= r0
  logic [RW-1:0]                r0_q;
  logic [CW-1:0]                a_q, x_q, y_q;
  logic [KB-1:0]                k_q;

  logic signed [AW-1:0]         trv_q    [NUM_AXES];
  logic signed [AW-1:0]         acc_lo_q [NUM_AXES];
  logic signed [AW-1:0]         acc_hi_q [NUM_AXES];
  logic                         run_open_q;

  logic                         out_valid_q;
  logic                         env_valid_q;
  logic [ENV_W-1:0]             env_lo_q [NUM_AXES];
  logic [ENV_W-1:0]             env_hi_q [NUM_AXES];

  logic signed [DIR_BITS-1:0]   dir_w   [NUM_AXES];
  logic [2*DIR_BITS-1:0]        sq_w    [NUM_AXES];
  logic signed [AW-1:0]         blo_w   [NUM_AXES];
  logic signed [AW-1:0]         bhi_w   [NUM_AXES];
  logic [SW-1:0]                s_w;
  logic [2*DIR_BITS-1:0]        ad2_w;
  logic [CW-1:0]                cand_w;
  logic                         fit_w;
  logic [KB:0]                  kp_w;
  logic signed [AW-1:0]         n_w;
  logic                         out_free_w;

  function automatic logic [ENV_W-1:0] sat_env(input logic signed [AW-1:0] v);
    logic signed [SATW-1:0] w, hi, lo;
    w  = SATW'(v);
    hi = SATW'({1'b0, {(ENV_W-1){1'b1}}});
    lo = ~hi;
    if (w > hi)      return hi[ENV_W-1:0];
    else if (w < lo) return lo[ENV_W-1:0];
    else             return w[ENV_W-1:0];
  endfunction

  assign dir_w[0] = dir_x_i;
  assign dir_w[1] = dir_y_i;
  assign dir_w[2] = dir_z_i;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sq_w[i]  = ad_q[i] * ad_q[i];
      // an inverted box spans the smaller to the larger corner
      blo_w[i] = (box_min_q[i] < box_max_q[i]) ? AW'(box_min_q[i]) : AW'(box_max_q[i]);
      bhi_w[i] = (box_min_q[i] < box_max_q[i]) ? AW'(box_max_q[i]) : AW'(box_min_q[i]);
    end
  end

  assign s_w    = SW'(sq_w[0]) + SW'(sq_w[1]) + SW'(sq_w[2]);
  assign ad2_w  = sq_w[cmd_i.axis];
  assign cand_w = a_q + x_q + y_q;
  assign fit_w  = cand_w <= CW'(r0_q);
  // round half away from zero: n = (k + 1) / 2
  assign kp_w   = {1'b0, k_q} + 1'b1;
  assign n_w    = signed'(AW'(kp_w[KB:1]));

  assign out_free_w  = !out_valid_q || out_ready_i;
  assign st_o.s_zero = (ad_q[0] == '0) && (ad_q[1] == '0) && (ad_q[2] == '0);
  assign st_o.last   = last_q;
  assign st_o.out_free = out_free_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
      box_valid_q <= 1'b0;
      ext_q       <= '0;
      run_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_BOX_MIN_X:    box_min_q[0] <= cfg_data_i;
          REG_BOX_MIN_Y:    box_min_q[1] <= cfg_data_i;
          REG_BOX_MIN_Z:    box_min_q[2] <= cfg_data_i;
          REG_BOX_MAX_X:    box_max_q[0] <= cfg_data_i;
          REG_BOX_MAX_Y:    box_max_q[1] <= cfg_data_i;
          REG_BOX_MAX_Z:    box_max_q[2] <= cfg_data_i;
          REG_BOX_VALID:    box_valid_q  <= cfg_data_i[0];
          REG_SCENE_EXTENT: ext_q        <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_LOAD) begin
        run_open_q <= 1'b1;
      end else if (cmd_i.op == OP_WIDEN && last_q) begin
        run_open_q <= 1'b0;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        last_q <= last_direction_i;
        for (int i = 0; i < NUM_AXES; i++) begin
          ad_q[i]   <= dir_w[i][DIR_BITS-1] ? -dir_w[i] : dir_w[i];
          dpos_q[i] <= !dir_w[i][DIR_BITS-1] && (dir_w[i] != '0);
          if (!run_open_q) begin
            acc_lo_q[i] <= blo_w[i];
            acc_hi_q[i] <= bhi_w[i];
          end
        end
      end
      OP_PREP: begin
        s_q      <= s_w;
        mcand_q  <= MW'(ext_q);
        mplier_q <= PLW'(ext_q);
        prod_q   <= '0;
        for (int i = 0; i < NUM_AXES; i++) trv_q[i] <= '0;
      end
      OP_MUL: begin
        if (mplier_q[0]) prod_q <= prod_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      OP_E2SAVE: e2_q <= prod_q[2*COORD_BITS-1:0];
      OP_AXINIT: begin
        mcand_q  <= MW'(e2_q);
        mplier_q <= PLW'(ad2_w);
        prod_q   <= '0;
      end
      OP_RTINIT: begin
        r0_q <= {prod_q, 2'b00};
        a_q  <= '0;
        x_q  <= '0;
        y_q  <= CW'(s_q) << (2 * COORD_BITS);
        k_q  <= '0;
      end
      OP_RTSTEP: begin
        // x tracks k*s shifted to the next bit, y tracks s shifted to the next bit pair
        if (fit_w) begin
          a_q <= cand_w;
          x_q <= (x_q >> 1) + y_q;
        end else begin
          x_q <= x_q >> 1;
        end
        y_q <= y_q >> 2;
        k_q <= {k_q[KB-2:0], fit_w};
      end
      OP_TRAVEL: trv_q[cmd_i.axis] <= dpos_q[cmd_i.axis] ? -n_w : n_w;
      OP_WIDEN: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (blo_w[i] + trv_q[i] < acc_lo_q[i]) acc_lo_q[i] <= blo_w[i] + trv_q[i];
          if (bhi_w[i] + trv_q[i] > acc_hi_q[i]) acc_hi_q[i] <= bhi_w[i] + trv_q[i];
        end
      end
      OP_EMIT: begin
        env_valid_q <= box_valid_q;
        for (int i = 0; i < NUM_AXES; i++) begin
          env_lo_q[i] <= box_valid_q ? sat_env(acc_lo_q[i]) : '0;
          env_hi_q[i] <= box_valid_q ? sat_env(acc_hi_q[i]) : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign env_valid_o = env_valid_q;
  assign env_min_x_o = env_lo_q[0];
  assign env_min_y_o = env_lo_q[1];
  assign env_min_z_o = env_lo_q[2];
  assign env_max_x_o = env_hi_q[0];
  assign env_max_y_o = env_hi_q[1];
  assign env_max_z_o = env_hi_q[2];

endmodule

### src/shadow_sweep_box_envelope.sv
// Each direction runs through the shift-add multiplier and the bit-serial root search;
// a zero-length direction skips both. One direction at a time; the last direction of a
// run also passes the emit state, which waits until the output register is free. The
// result sits in an output register, so the next direction may enter while it waits.
// Reset: asynchronous, active low; clears configuration registers, controller state, run state and output valid.
module shadow_sweep_box_envelope #(
  parameter int DIR_BITS   = 16,
  parameter int COORD_BITS = 31
) (
  input logic        clk_i,
  input logic        rst_ni,
  ssbe_in_if.sink    in_ch,
  ssbe_out_if.source out_ch,
  ssbe_cfg_if.sink   cfg_ch
);
  import ssbe_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ch.ready = 1'b1;

  ssbe_ctrl #(.DIR_BITS(DIR_BITS), .COORD_BITS(COORD_BITS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  ssbe_dp #(.DIR_BITS(DIR_BITS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .dir_x_i          (in_ch.dir_x),
    .dir_y_i          (in_ch.dir_y),
    .dir_z_i          (in_ch.dir_z),
    .last_direction_i (in_ch.last_direction),
    .cfg_we_i         (cfg_ch.valid),
    .cfg_index_i      (cfg_ch.index),
    .cfg_data_i       (cfg_ch.data),
    .out_valid_o      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .env_valid_o      (out_ch.env_valid),
    .env_min_x_o      (out_ch.env_min_x),
    .env_min_y_o      (out_ch.env_min_y),
    .env_min_z_o      (out_ch.env_min_z),
    .env_max_x_o      (out_ch.env_max_x),
    .env_max_y_o      (out_ch.env_max_y),
    .env_max_z_o      (out_ch.env_max_z)
  );

endmodule

### src/ssbe_checker.sv
// Port-level checks of the swept box envelope, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        env_valid_i,
  input logic [31:0] env_min_x_i,
  input logic [31:0] env_min_y_i,
  input logic [31:0] env_min_z_i,
  input logic [31:0] env_max_x_i,
  input logic [31:0] env_max_y_i,
  input logic [31:0] env_max_z_i
);

  // the block is busy on the cycle after a transfer in
  `SSBE_ASSERT_NXT(busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // no result appears in the cycle after an item is taken while the output was empty
  `SSBE_ASSERT_NXT(no_instant_result, clk_i, rst_ni, in_valid_i && in_ready_i && !out_valid_i, !out_valid_i)

  // an invalid envelope carries zero corners
  `SSBE_ASSERT_IMP(invalid_is_zero, clk_i, rst_ni, out_valid_i && !env_valid_i, (env_min_x_i == 32'd0) && (env_min_y_i == 32'd0) && (env_min_z_i == 32'd0) && (env_max_x_i == 32'd0) && (env_max_y_i == 32'd0) && (env_max_z_i == 32'd0))

  // a stalled result holds
  `SSBE_ASSERT_NXT(out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(env_min_x_i) && $stable(env_max_z_i))

endmodule

bind shadow_sweep_box_envelope ssbe_checker u_ssbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .env_valid_i (out_ch.env_valid),
  .env_min_x_i (out_ch.env_min_x),
  .env_min_y_i (out_ch.env_min_y),
  .env_min_z_i (out_ch.env_min_z),
  .env_max_x_i (out_ch.env_max_x),
  .env_max_y_i (out_ch.env_max_y),
  .env_max_z_i (out_ch.env_max_z)
);

### dv/tb.sv
// Testbench for shadow_sweep_box_envelope: random direction runs checked against
// a scoreboard that predicts the swept envelope. Depends on ssbe_pkg and the ssbe_*_if files.
module tb;
  import ssbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRW      = 16;
  localparam int CRDW      = 31;
  localparam int WAIT_IDLE = 300;
  localparam int LIMIT     = 4_000_000;
  localparam int N_ITEMS   = 1850;

  typedef struct {
    bit env_valid;
    int lo[3];
    int hi[3];
  } envelope_t;

  class envelope_board;
    logic [CRDW-1:0] regs[8];
    bit              run_open;
    longint          acc_lo[3], acc_hi[3];
    envelope_t       pending[$];
    int              errors;

    function void reg_write(int idx, logic [CRDW-1:0] v);
      regs[idx] = (idx == REG_BOX_VALID) ? (v & 1) : v;
    endfunction

    function longint coord(int idx);
      logic signed [CRDW-1:0] v;
      v = regs[idx];
      return longint'(v);
    endfunction

    // magnitude is the largest n with (2n-1)^2 * s <= (2|d|ext)^2, sign opposite to d
    function longint travel(longint d, longint ext, longint s);
      logic [127:0] rhs, lhs, k;
      longint ad, n, c;
      ad  = (d < 0) ? -d : d;
      rhs = 128'(2 * ad * ext);
      rhs = rhs * rhs;
      n   = 0;
      for (int b = CRDW - 1; b >= 0; b--) begin
        c   = n | (longint'(1) << b);
        k   = 128'(2 * c - 1);
        lhs = k * k * 128'(s);
        if (lhs <= rhs) n = c;
      end
      return (d > 0) ? -n : n;
    endfunction

    function int clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function void note_dir(logic signed [DIRW-1:0] dx, dy, dz, bit last);
      longint d[3], s, t, a, b, lo, hi;
      envelope_t e;
      d[0] = dx; d[1] = dy; d[2] = dz;
      s = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      for (int ax = 0; ax < 3; ax++) begin
        a  = coord(ax);
        b  = coord(ax + 3);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (!run_open) begin
          acc_lo[ax] = lo;
          acc_hi[ax] = hi;
        end
        t = (s != 0) ? travel(d[ax], longint'(regs[REG_SCENE_EXTENT]), s) : 0;
        if (lo + t < acc_lo[ax]) acc_lo[ax] = lo + t;
        if (hi + t > acc_hi[ax]) acc_hi[ax] = hi + t;
      end
      run_open = 1;
      if (!last) return;
      run_open    = 0;
      e.env_valid = regs[REG_BOX_VALID][0];
      for (int ax = 0; ax < 3; ax++) begin
        e.lo[ax] = e.env_valid ? clip(acc_lo[ax]) : 0;
        e.hi[ax] = e.env_valid ? clip(acc_hi[ax]) : 0;
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check(envelope_t act);
      envelope_t e;
      string ax_name[3];
      ax_name = '{"x", "y", "z"};
      if (pending.size() == 0) begin
        $error("unexpected envelope transfer");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.env_valid != act.env_valid) begin
        $error("env_valid: exp %0d act %0d", e.env_valid, act.env_valid);
        errors++;
      end
      for (int ax = 0; ax < 3; ax++) begin
        if (e.lo[ax] != act.lo[ax]) begin
          $error("env_min_%s: exp %0d act %0d", ax_name[ax], e.lo[ax], act.lo[ax]);
          errors++;
        end
        if (e.hi[ax] != act.hi[ax]) begin
          $error("env_max_%s: exp %0d act %0d", ax_name[ax], e.hi[ax], act.hi[ax]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycles;
  int   burst_left;
  int   items_sent;
  envelope_board board;

  ssbe_in_if  #(.DIR_BITS(DIRW))   in_ch ();
  ssbe_out_if                      out_ch ();
  ssbe_cfg_if #(.COORD_BITS(CRDW)) cfg_ch ();

  shadow_sweep_box_envelope #(.DIR_BITS(DIRW), .COORD_BITS(CRDW)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result sink with a stall pattern that rotates through always ready, random ready and mostly stalled
  always @(posedge clk_i) begin
    envelope_t act;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      act.env_valid = out_ch.env_valid;
      act.lo = '{out_ch.env_min_x, out_ch.env_min_y, out_ch.env_min_z};
      act.hi = '{out_ch.env_max_x, out_ch.env_max_y, out_ch.env_max_z};
      board.check(act);
    end
    case ((cycles / 500) % 3)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CRDW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.reg_write(idx, v);
  endtask

  // input goes idle here so a held item is not taken twice
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (WAIT_IDLE) @(posedge clk_i);
  endtask

  task automatic load_box(longint mnx, mny, mnz, mxx, mxy, mxz, bit vld, longint ext);
    wait_drained();
    cfg_write(REG_BOX_MIN_X, CRDW'(mnx));
    cfg_write(REG_BOX_MIN_Y, CRDW'(mny));
    cfg_write(REG_BOX_MIN_Z, CRDW'(mnz));
    cfg_write(REG_BOX_MAX_X, CRDW'(mxx));
    cfg_write(REG_BOX_MAX_Y, CRDW'(mxy));
    cfg_write(REG_BOX_MAX_Z, CRDW'(mxz));
    cfg_write(REG_BOX_VALID, CRDW'(vld));
    cfg_write(REG_SCENE_EXTENT, CRDW'(ext));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_dir(int dx, int dy, int dz, bit last);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid          <= 1'b1;
    in_ch.dir_x          <= DIRW'(dx);
    in_ch.dir_y          <= DIRW'(dy);
    in_ch.dir_z          <= DIRW'(dz);
    in_ch.last_direction <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_dir(DIRW'(dx), DIRW'(dy), DIRW'(dz), last);
    burst_left--;
    items_sent++;
  endtask

  function automatic int rand_comp();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return -32768;
      2: return 32767;
      3: return $urandom_range(0, 40) - 20;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic random_runs(int count);
    int n, zero_len;
    while (count > 0) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        zero_len = ($urandom_range(0, 11) == 0);
        if (zero_len) send_dir(0, 0, 0, i == n - 1);
        else send_dir(rand_comp(), rand_comp(), rand_comp(), i == n - 1);
      end
      count -= n;
    end
    burst_left = 0;
  endtask

  function automatic longint rand_crd();
    if ($urandom_range(0, 3) == 0) return longint'($signed(CRDW'($urandom)));
    return longint'($urandom_range(0, 200000)) - 100000;
  endfunction

  initial begin
    board        = new();
    cycles       = 0;
    burst_left   = 0;
    items_sent   = 0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.dir_x  = '0;
    in_ch.dir_y  = '0;
    in_ch.dir_z  = '0;
    in_ch.last_direction = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BOX_MIN_X;
    cfg_ch.data  = '0;
    for (int i = 0; i < 8; i++) board.reg_write(i, '0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: box invalid, all-zero envelope
    send_dir(3, 4, 0, 1'b1);

    load_box(-100, -200, -300, 100, 200, 300, 1'b1, 1000);
    send_dir(0, 0, 0, 1'b1);                       // empty run gives the box
    send_dir(1, 0, 0, 1'b0);
    send_dir(-1, 0, 0, 1'b0);
    send_dir(0, 1, 0, 1'b0);
    send_dir(0, -1, 0, 1'b0);
    send_dir(0, 0, 32767, 1'b0);
    send_dir(0, 0, -32768, 1'b1);
    send_dir(-32768, -32768, -32768, 1'b1);
    send_dir(32767, 32767, 32767, 1'b0);
    send_dir(0, 0, 0, 1'b1);
    send_dir(1, 1, 0, 1'b1);                       // diagonal direction whose length is not a whole number
    send_dir(3, 4, 0, 1'b1);

    // extreme box and sweep that can drive outputs into saturation
    load_box(-(1 << 30), -(1 << 30), -(1 << 30), (1 << 30) - 1, (1 << 30) - 1,
             (1 << 30) - 1, 1'b1, 1 << 30);
    send_dir(32767, -32768, 1, 1'b1);
    send_dir(-32768, 32767, -1, 1'b0);
    send_dir(5, 5, 5, 1'b1);
    random_runs(200);

    // inverted box
    load_box(500, -50, 70, -500, -90, 10, 1'b1, 12345);
    send_dir(-7, 2, 9, 1'b1);
    random_runs(230);

    // no sweep
    load_box(-8, -9, -10, 8, 9, 10, 1'b1, 0);
    random_runs(230);

    // invalid box
    load_box(rand_crd(), rand_crd(), rand_crd(), rand_crd(), rand_crd(), rand_crd(),
             1'b0, $urandom_range(0, 1 << 30));
    random_runs(200);

    while (items_sent < N_ITEMS) begin
      load_box(rand_crd(), rand_crd(), rand_crd(), rand_crd(), rand_crd(), rand_crd(),
               $urandom_range(0, 7) != 0,
               ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1 << 30)
                                           : $urandom_range(0, 5000));
      random_runs(250);
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### shadow_sweep_box_envelope.f
+incdir+src
src/ssbe_pkg.sv
src/ssbe_if.sv
src/ssbe_ctrl.sv
src/ssbe_dp.sv
src/shadow_sweep_box_envelope.sv
src/ssbe_checker.sv
dv/tb.sv
